>>> hw/rtl/scss_pkg.sv
// shared types and constants for the serial commanded stepper sequencer
// no dependencies; used by the front, queue, back, top level and checker
package scss_pkg;

	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_BIG_F = 8'h46;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	localparam logic [9:0] RELOAD_RESET = 10'd199;
	localparam logic [1:0] DIR_RESET    = 2'b01;

	localparam logic [3:0] COIL_TABLE [4] = '{4'h3, 4'h6, 4'hC, 4'h9};

	typedef enum logic [1:0] {
		KIND_ERR  = 2'd0,
		KIND_ECHO = 2'd1,
		KIND_STEP = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t           kind;
		logic [3:0][7:0] chars;
		logic [3:0]      coil;
		logic            led;
		logic            running;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

>>> hw/rtl/scss_front.sv
// front end: command parser, step timer and coil state; emits one job per result group
// depends on scss_pkg
module scss_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_func,
	input  logic [7:0]       in_byte,
	output logic             in_ready,
	input  logic             cfg_valid,
	input  logic [1:0]       cfg_data,
	input  scss_pkg::q_stat_t q_stat,
	output logic             push,
	output scss_pkg::job_t   push_job
);

	logic [1:0]  pos_q;
	logic [7:0]  chars_q [3];
	logic [9:0]  reload_active_q;
	logic [9:0]  reload_pending_q;
	logic [9:0]  tick_q;
	logic        running_q;
	logic [10:0] steps_q;
	logic [1:0]  step_pos_q;
	logic [3:0]  coil_q;
	logic        led_q;
	logic [1:0]  dir_q;

	logic        accept;
	logic        letter;
	logic        digit;
	logic        char_ok;
	logic [9:0]  value;
	logic        wrap;
	logic        count_done;

	logic [1:0]  pos_d;
	logic [9:0]  reload_active_d;
	logic [9:0]  reload_pending_d;
	logic [9:0]  tick_d;
	logic        running_d;
	logic [10:0] steps_d;
	logic [1:0]  step_pos_d;
	logic [3:0]  coil_d;
	logic        led_d;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	assign letter  = (in_byte == scss_pkg::CH_S) || (in_byte == scss_pkg::CH_F) ||
			 (in_byte == scss_pkg::CH_N);
	assign digit   = (in_byte >= scss_pkg::CH_0) && (in_byte <= scss_pkg::CH_9);
	assign char_ok = (pos_q == 2'd0) ? letter : digit;

	// digits are 0x30..0x39, so the low nibble is the digit value
	assign value = 10'(chars_q[1][3:0]) * 10'd100 + 10'(chars_q[2][3:0]) * 10'd10 +
		       10'(in_byte[3:0]);

	assign wrap       = tick_q >= reload_active_q;
	assign count_done = (steps_q == 11'd0);

	always_comb begin
		pos_d            = pos_q;
		reload_active_d  = reload_active_q;
		reload_pending_d = reload_pending_q;
		tick_d           = tick_q;
		running_d        = running_q;
		steps_d          = steps_q;
		step_pos_d       = step_pos_q;
		coil_d           = coil_q;
		led_d            = led_q;
		push             = 1'b0;
		push_job.kind    = scss_pkg::KIND_ERR;
		push_job.chars   = {in_byte, chars_q[2], chars_q[1], chars_q[0]};
		if (accept) begin
			if (!in_func) begin
				if (char_ok) begin
					if (pos_q == 2'd3) begin
						pos_d         = 2'd0;
						push          = 1'b1;
						push_job.kind = scss_pkg::KIND_ECHO;
						if (chars_q[0] == scss_pkg::CH_F) begin
							if (value == 10'd0) begin
								running_d = 1'b0;
							end else begin
								tick_d           = 10'd0;
								reload_pending_d = value;
								running_d        = 1'b1;
							end
						end else if (chars_q[0] == scss_pkg::CH_N) begin
							steps_d   = 11'(value);
							tick_d    = 10'd0;
							running_d = 1'b1;
						end
					end else begin
						pos_d = pos_q + 2'd1;
					end
				end else begin
					pos_d         = 2'd0;
					push          = 1'b1;
					push_job.kind = scss_pkg::KIND_ERR;
				end
			end else if (running_q) begin
				if (wrap) begin
					tick_d          = 10'd0;
					reload_active_d = reload_pending_q;
					push            = 1'b1;
					push_job.kind   = scss_pkg::KIND_STEP;
					if (!steps_q[10]) begin
						steps_d = steps_q - 11'd1;
					end
					if (count_done) begin
						running_d = 1'b0;
					end else begin
						coil_d     = scss_pkg::COIL_TABLE[step_pos_q];
						led_d      = !led_q;
						step_pos_d = step_pos_q + dir_q;
					end
				end else begin
					tick_d = tick_q + 10'd1;
				end
			end
		end
		push_job.coil    = coil_d;
		push_job.led     = led_d;
		push_job.running = running_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q            <= 2'd0;
			reload_active_q  <= scss_pkg::RELOAD_RESET;
			reload_pending_q <= scss_pkg::RELOAD_RESET;
			tick_q           <= 10'd0;
			running_q        <= 1'b1;
			steps_q          <= 11'd0;
			step_pos_q       <= 2'd0;
			coil_q           <= 4'd0;
			led_q            <= 1'b0;
			dir_q            <= scss_pkg::DIR_RESET;
		end else begin
			pos_q            <= pos_d;
			reload_active_q  <= reload_active_d;
			reload_pending_q <= reload_pending_d;
			tick_q           <= tick_d;
			running_q        <= running_d;
			steps_q          <= steps_d;
			step_pos_q       <= step_pos_d;
			coil_q           <= coil_d;
			led_q            <= led_d;
			if (cfg_valid) begin
				dir_q <= cfg_data;
			end
		end
	end

	// command characters, no reset
	always_ff @(posedge clk) begin
		if (accept && !in_func && char_ok && (pos_q != 2'd3)) begin
			chars_q[pos_q] <= in_byte;
		end
	end

endmodule

>>> hw/rtl/scss_queue.sv
// job queue between the front end and the beat generator
// depends on scss_pkg
module scss_queue #(
	parameter int QDEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  scss_pkg::job_t    push_job,
	input  logic              pop,
	output scss_pkg::job_t    head_job,
	output scss_pkg::q_stat_t stat
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	scss_pkg::job_t mem_q [QDEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign stat.full  = (count_q == CW'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

>>> hw/rtl/scss_back.sv
// back end: expands the head job into one or four output beats
// depends on scss_pkg
module scss_back (
	input  logic              clk,
	input  logic              arst_n,
	input  scss_pkg::job_t    head_job,
	input  scss_pkg::q_stat_t q_stat,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_tx_valid,
	output logic [7:0]        out_tx_byte,
	output logic [3:0]        out_coil,
	output logic              out_led,
	output logic              out_running,
	output logic              out_last
);

	logic [1:0] beat_q;
	logic       beat_done;

	assign out_valid   = !q_stat.empty;
	assign out_coil    = head_job.coil;
	assign out_led     = head_job.led;
	assign out_running = head_job.running;

	always_comb begin
		unique case (head_job.kind)
			scss_pkg::KIND_ERR: begin
				out_tx_valid = 1'b1;
				out_tx_byte  = scss_pkg::CH_BIG_F;
				out_last     = 1'b1;
			end
			scss_pkg::KIND_ECHO: begin
				out_tx_valid = 1'b1;
				out_tx_byte  = head_job.chars[beat_q];
				out_last     = (beat_q == 2'd3);
			end
			default: begin
				out_tx_valid = 1'b0;
				out_tx_byte  = 8'd0;
				out_last     = 1'b1;
			end
		endcase
	end

	assign beat_done = out_valid && out_ready;
	assign pop       = beat_done && out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= 2'd0;
		end else if (beat_done) begin
			beat_q <= out_last ? 2'd0 : beat_q + 2'd1;
		end
	end

endmodule

>>> hw/rtl/serial_commanded_stepper_sequencer_core.sv
// Serial commanded full-step stepper sequencer. Each input beat is a received
// serial byte (s_tuser = 0) or one prescaled timer tick (s_tuser = 1); the front
// end takes one beat per cycle while its job queue (QDEPTH jobs) has room. A
// rejected byte gives one 'F' beat, a completed four-character command gives four
// echo beats, a timer wrap gives one step beat (m_tuser = 0). The beat generator
// sends one output beat per cycle while m_tready is high, so a command echo takes
// four output beats and a single-beat result one; the queue decouples both sides.
// Depends on scss_pkg, scss_front, scss_queue and scss_back.
module serial_commanded_stepper_sequencer_core #(
	parameter int QDEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] tx_byte, [11:8] coil_pattern, [12] led, [13] running
	output logic        m_tuser,   // [0] tx_valid
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data   // direction
);

	scss_pkg::q_stat_t q_stat;
	scss_pkg::job_t    push_job;
	scss_pkg::job_t    head_job;
	logic              push;
	logic              pop;
	logic [7:0]        tx_byte;
	logic [3:0]        coil;
	logic              led;
	logic              running;

	assign cfg_ready = 1'b1;

	scss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_func   (s_tuser),
		.in_byte   (s_tdata),
		.in_ready  (s_tready),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_job  (push_job)
	);

	scss_queue #(
		.QDEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.stat     (q_stat)
	);

	scss_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_job     (head_job),
		.q_stat       (q_stat),
		.pop          (pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_tx_valid (m_tuser),
		.out_tx_byte  (tx_byte),
		.out_coil     (coil),
		.out_led      (led),
		.out_running  (running),
		.out_last     (m_tlast)
	);

	assign m_tdata = {2'b00, running, led, coil, tx_byte};

endmodule

>>> hw/rtl/scss_checker.sv
// port-level checker for the stepper sequencer core, bound to the top level
// depends on scss_pkg
module scss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// step beats stand alone
	a_step_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("step beat without tlast");

	// step beats carry no serial byte
	a_step_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata[7:0] == 8'd0))
		else $error("step beat with nonzero tx byte");

	// an error reply is a single beat, echo characters are never 'F'
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && (m_tdata[7:0] == scss_pkg::CH_BIG_F) |-> m_tlast)
		else $error("error beat without tlast");

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
			$stable(m_tlast))
		else $error("stalled output beat changed");

endmodule

bind serial_commanded_stepper_sequencer_core scss_checker u_scss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
